// File: src/y2r_pkg.sv
`timescale 1ns / 1ps

package y2r_pkg;

  // YUV-to-RGB coefficients, scaled by 1000
  localparam logic signed [19:0] COEF_Y  = 20'sd1164;
  localparam logic signed [18:0] COEF_RV = 19'sd1159;
  localparam logic signed [16:0] COEF_GU = 17'sd380;
  localparam logic signed [17:0] COEF_GV = 18'sd813;
  localparam logic signed [19:0] COEF_BU = 20'sd2018;

  localparam logic signed [8:0] Y_OFFS = 9'sd16;
  localparam logic signed [8:0] C_OFFS = 9'sd128;

  // Divide by 1000 as multiply by ceil(2^28 / 1000), then shift by 28.
  // This is exact for every dividend below 256000.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [18:0] SCALE_RECIP = 19'd268436;

  // Largest dividend that still gives 255 after the divide
  localparam logic [17:0] CLIP_MAX = 18'd255999;

  // Scaled channel after clamping, ready for the divide
  typedef logic [17:0] chan_t;
  // Product of a scaled channel and the reciprocal
  typedef logic [36:0] prod_t;

  // Clamp a scaled channel sum to 0..CLIP_MAX
  function automatic chan_t clip_chan(input logic signed [20:0] s);
    chan_t res;
    if (s[20]) begin
      res = '0;
    end else if (s > $signed({3'b000, CLIP_MAX})) begin
      res = CLIP_MAX;
    end else begin
      res = s[17:0];
    end
    return res;
  endfunction

  // Pack three 8-bit channels as RGB565
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: src/yuv422_pair_to_rgb565_unit.sv
`timescale 1ns / 1ps

// Throughput: one pair per cycle; busy is held low, the four stages
// (chroma/luma multiply, green term add, sum and clamp, divide and pack)
// never stall since the receiver takes every result.
// Reset clears the stage valid bits only; no result follows reset.
module yuv422_pair_to_rgb565_unit
  import y2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  luma_first,
  input  logic [7:0]  luma_second,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  chroma_red,
  input  logic        frame_end_in,
  output logic        done,
  output logic [15:0] rgb_first,
  output logic [15:0] rgb_second,
  output logic        frame_end_out
);

  // Stage valid bits
  logic v1, v2, v3, v4;

  // Stage 1 registers: products
  logic signed [19:0] ys1 [2];
  logic signed [18:0] rt1;
  logic signed [16:0] gu1;
  logic signed [17:0] gv1;
  logic signed [19:0] bt1;
  logic               fe1;

  // Stage 2 registers: chroma terms
  logic signed [19:0] ys2 [2];
  logic signed [18:0] rt2;
  logic signed [18:0] gt2;
  logic signed [19:0] bt2;
  logic               fe2;

  // Stage 3 registers: clamped scaled channels, [pixel][r,g,b]
  chan_t u3 [2][3];
  logic  fe3;

  // Stage 1 combinational
  logic signed [8:0] y_s [2];
  logic signed [8:0] cb_s, cr_s;

  // Stage 3 and 4 combinational
  logic signed [20:0] sum [2][3];
  chan_t              u_next [2][3];
  logic [7:0]         q [2][3];

  assign busy = 1'b0;

  // Remove offsets from samples
  always_comb begin
    y_s[0] = $signed({1'b0, luma_first}) - Y_OFFS;
    y_s[1] = $signed({1'b0, luma_second}) - Y_OFFS;
    cb_s   = $signed({1'b0, chroma_blue}) - C_OFFS;
    cr_s   = $signed({1'b0, chroma_red}) - C_OFFS;
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: one multiply per term
  always_ff @(posedge clk) begin
    ys1[0] <= 20'(y_s[0]) * COEF_Y;
    ys1[1] <= 20'(y_s[1]) * COEF_Y;
    rt1    <= 19'(cr_s) * COEF_RV;
    gu1    <= 17'(cb_s) * COEF_GU;
    gv1    <= 18'(cr_s) * COEF_GV;
    bt1    <= 20'(cb_s) * COEF_BU;
    fe1    <= frame_end_in;
  end

  // Stage 2: combine the green chroma term
  always_ff @(posedge clk) begin
    ys2[0] <= ys1[0];
    ys2[1] <= ys1[1];
    rt2    <= rt1;
    gt2    <= 19'(gu1) + 19'(gv1);
    bt2    <= bt1;
    fe2    <= fe1;
  end

  // Stage 3: form each channel and clamp it to the divide range
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sum[p][0]    = 21'(ys2[p]) + 21'(rt2);
      sum[p][1]    = 21'(ys2[p]) - 21'(gt2);
      sum[p][2]    = 21'(ys2[p]) + 21'(bt2);
      for (int c = 0; c < 3; c++) begin
        u_next[p][c] = clip_chan(sum[p][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    u3  <= u_next;
    fe3 <= fe2;
  end

  // Stage 4: divide by 1000 through the reciprocal
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      for (int c = 0; c < 3; c++) begin
        q[p][c] = 8'((prod_t'(u3[p][c]) * prod_t'(SCALE_RECIP)) >> RECIP_SHIFT);
      end
    end
  end

  // Pack and hold the result
  always_ff @(posedge clk) begin
    rgb_first     <= pack565(q[0][0], q[0][1], q[0][2]);
    rgb_second    <= pack565(q[1][0], q[1][1], q[1][2]);
    frame_end_out <= fe3;
  end

  assign done = v4;

`ifndef SYNTHESIS
  // Every accepted item gives its result, marked by done
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##4 done)
    else $error("accepted item did not produce a result");

  // No result without a matching accepted item
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without accepted item");

  // Frame end marker travels with its item
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    done |-> (frame_end_out == $past(frame_end_in, 4)))
    else $error("frame end marker mismatch");

  // Black luma with neutral chroma gives a black first pixel
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && (luma_first <= 8'd16) && (chroma_blue == 8'd128) &&
     (chroma_red == 8'd128)) |-> ##4 (rgb_first == 16'h0000))
    else $error("black input did not give a black pixel");
`endif

endmodule
